// File: rtl/modbus_tcp_request_deframer_assert.svh
// assertion macros shared by the deframer checks
`ifndef MODBUS_TCP_REQUEST_DEFRAMER_ASSERT_SVH
`define MODBUS_TCP_REQUEST_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define MTRD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MTRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mtrd_pkg.sv
// types, constants and helpers of the modbus tcp request deframer
`timescale 1ns / 1ps

package mtrd_pkg;

    localparam int MTRD_MAX_FRAME_BYTES = 260;

    // result queue depth
    localparam int RQ_DEPTH = 4;

    // byte positions in the frame
    localparam int POS_TRANS_HI = 0;
    localparam int POS_TRANS_LO = 1;
    localparam int POS_LEN_HI   = 4;
    localparam int POS_LEN_LO   = 5;
    localparam int POS_UNIT     = 6;
    localparam int POS_FUNC     = 7;
    localparam int POS_ADDR_HI  = 8;
    localparam int POS_ADDR_LO  = 9;
    localparam int POS_QTY_HI   = 10;
    localparam int POS_QTY_LO   = 11;
    localparam int POS_BCOUNT   = 12;
    localparam int POS_DATA     = 13;

    // function codes with special bodies
    localparam logic [7:0] FUNC_WRITE_SINGLE_COIL = 8'd5;
    localparam logic [7:0] FUNC_WRITE_SINGLE_REG  = 8'd6;
    localparam logic [7:0] FUNC_WRITE_MULTI_COILS = 8'd15;
    localparam logic [7:0] FUNC_WRITE_MULTI_REGS  = 8'd16;
    localparam logic [7:0] FUNC_READ_FIRST        = 8'd1;

    // result kinds
    localparam logic [1:0] KIND_REG_WORD  = 2'd0;
    localparam logic [1:0] KIND_COIL_BYTE = 2'd1;
    localparam logic [1:0] KIND_SUMMARY   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] txn_id;
        logic [7:0]  unit_id;
        logic [7:0]  func;
        logic [15:0] base_addr;
        logic [15:0] quantity;
        logic [15:0] value;
        logic [7:0]  index;
        logic        length_ok;
        logic        known_func;
        logic        last;
    } out_word_t;

    // up to two results produced by one accepted byte
    typedef struct packed {
        logic      first_valid;
        logic      second_valid;
        out_word_t first;
        out_word_t second;
    } rslt_push_t;

    function automatic logic func_single(logic [7:0] f);
        return (f == FUNC_WRITE_SINGLE_COIL) || (f == FUNC_WRITE_SINGLE_REG);
    endfunction

    function automatic logic func_known(logic [7:0] f);
        return ((f >= FUNC_READ_FIRST) && (f <= FUNC_WRITE_SINGLE_REG))
            || (f == FUNC_WRITE_MULTI_COILS) || (f == FUNC_WRITE_MULTI_REGS);
    endfunction

endpackage

// File: rtl/mtrd_parser.sv
// byte position tracking and field capture for one frame
`timescale 1ns / 1ps

module mtrd_parser import mtrd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MTRD_MAX_FRAME_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  in_word_t   in_word,
    output rslt_push_t push
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0] trans_reg, trans_next;
    logic [7:0]  unit_reg, unit_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] qty_reg, qty_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  coil_count_reg, coil_count_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  count_reg, count_next;

    logic        was_full;
    logic [POS_W-1:0] pos_step;
    logic        val_emit;
    logic [1:0]  val_kind;
    logic [15:0] val_word;
    logic        cur_known, cur_single;
    logic [7:0]  b;
    logic        len_ok;

    always_comb begin
        b          = in_word.data_byte;
        cur_known  = func_known(func_reg);
        cur_single = func_single(func_reg);
        was_full   = pos_reg >= POS_W'(MAX_FRAME_BYTES);
        pos_step   = was_full ? pos_reg : pos_reg + 1'b1;

        pos_next        = pos_reg;
        trans_next      = trans_reg;
        unit_next       = unit_reg;
        func_next       = func_reg;
        addr_next       = addr_reg;
        qty_next        = qty_reg;
        length_next     = length_reg;
        coil_count_next = coil_count_reg;
        hold_next       = hold_reg;
        count_next      = count_reg;
        val_emit        = 1'b0;
        val_kind        = KIND_REG_WORD;
        val_word        = '0;

        if (in_fire && !was_full) begin
            pos_next = pos_step;
            unique case (pos_reg)
                POS_W'(POS_TRANS_HI): trans_next  = {b, trans_reg[7:0]};
                POS_W'(POS_TRANS_LO): trans_next  = {trans_reg[15:8], b};
                POS_W'(POS_LEN_HI):   length_next = {b, length_reg[7:0]};
                POS_W'(POS_LEN_LO):   length_next = {length_reg[15:8], b};
                POS_W'(POS_UNIT):     unit_next   = b;
                POS_W'(POS_FUNC):     func_next   = b;
                POS_W'(POS_ADDR_HI): begin
                    if (cur_known) addr_next = {b, addr_reg[7:0]};
                end
                POS_W'(POS_ADDR_LO): begin
                    if (cur_known) addr_next = {addr_reg[15:8], b};
                end
                POS_W'(POS_QTY_HI): begin
                    if (cur_single) begin
                        hold_next = b;
                    end else if (cur_known) begin
                        qty_next = {b, qty_reg[7:0]};
                    end
                end
                POS_W'(POS_QTY_LO): begin
                    if (cur_single) begin
                        val_emit   = 1'b1;
                        val_word   = {hold_reg, b};
                        count_next = 8'd1;
                    end else if (cur_known) begin
                        qty_next = {qty_reg[15:8], b};
                    end
                end
                POS_W'(POS_BCOUNT): begin
                    if (func_reg == FUNC_WRITE_MULTI_COILS) coil_count_next = b;
                end
                default: begin
                    // data area: coil bytes or register word pairs
                    if (pos_reg >= POS_W'(POS_DATA) && count_reg != 8'hFF) begin
                        if (func_reg == FUNC_WRITE_MULTI_COILS) begin
                            if (count_reg < coil_count_reg) begin
                                val_emit   = 1'b1;
                                val_kind   = KIND_COIL_BYTE;
                                val_word   = {8'h00, b};
                                count_next = count_reg + 8'd1;
                            end
                        end else if (func_reg == FUNC_WRITE_MULTI_REGS) begin
                            // odd positions carry the high byte of each word
                            if (pos_reg[0]) begin
                                hold_next = b;
                            end else if (16'(count_reg) < qty_reg) begin
                                val_emit   = 1'b1;
                                val_word   = {hold_reg, b};
                                count_next = count_reg + 8'd1;
                            end
                        end
                    end
                end
            endcase
        end

        // length field including a low byte taken in this same cycle
        len_ok = !was_full && (pos_step >= POS_W'(POS_UNIT))
            && (length_next == 16'(pos_step) - 16'(POS_UNIT));

        push.first_valid       = val_emit;
        push.first.kind        = val_kind;
        push.first.txn_id      = trans_reg;
        push.first.unit_id     = unit_reg;
        push.first.func        = func_reg;
        push.first.base_addr   = addr_reg;
        push.first.quantity    = cur_single ? 16'd1 : qty_reg;
        push.first.value       = val_word;
        push.first.index       = count_reg;
        push.first.length_ok   = 1'b0;
        push.first.known_func  = cur_known;
        push.first.last        = 1'b0;

        push.second_valid      = in_fire && in_word.end_of_frame;
        push.second.kind       = KIND_SUMMARY;
        push.second.txn_id     = trans_next;
        push.second.unit_id    = unit_next;
        push.second.func       = func_next;
        push.second.base_addr  = addr_next;
        push.second.quantity   = func_single(func_next) ? 16'd1 : qty_next;
        push.second.value      = '0;
        push.second.index      = '0;
        push.second.length_ok  = len_ok;
        push.second.known_func = func_known(func_next);
        push.second.last       = 1'b1;

        if (in_fire && in_word.end_of_frame) begin
            pos_next        = '0;
            trans_next      = '0;
            unit_next       = '0;
            func_next       = '0;
            addr_next       = '0;
            qty_next        = '0;
            length_next     = '0;
            coil_count_next = '0;
            hold_next       = '0;
            count_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            trans_reg      <= '0;
            unit_reg       <= '0;
            func_reg       <= '0;
            addr_reg       <= '0;
            qty_reg        <= '0;
            length_reg     <= '0;
            coil_count_reg <= '0;
            hold_reg       <= '0;
            count_reg      <= '0;
        end else begin
            pos_reg        <= pos_next;
            trans_reg      <= trans_next;
            unit_reg       <= unit_next;
            func_reg       <= func_next;
            addr_reg       <= addr_next;
            qty_reg        <= qty_next;
            length_reg     <= length_next;
            coil_count_reg <= coil_count_next;
            hold_reg       <= hold_next;
            count_reg      <= count_next;
        end
    end

endmodule

// File: rtl/mtrd_result_queue.sv
// small result queue taking up to two words per cycle
`timescale 1ns / 1ps

module mtrd_result_queue import mtrd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  rslt_push_t push,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data
);

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    out_word_t mem_reg [RQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] second_addr;
    logic             pop;

    always_comb begin
        pop         = m_valid && m_ready;
        second_addr = push.first_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.first_valid) + PTR_W'(push.second_valid);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
            - CNT_W'(pop);
    end

    // two free slots cover the worst case of one byte
    assign room    = count_reg <= CNT_W'(RQ_DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.first_valid) mem_reg[wr_ptr_reg] <= push.first;
        if (push.second_valid) mem_reg[second_addr] <= push.second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/modbus_tcp_request_deframer.sv
// top level of the modbus tcp request deframer
`timescale 1ns / 1ps

// Modbus TCP request deframer. Takes one request byte per word on the s_ channel,
// with end_of_frame set on the final byte, and accepts a byte whenever the result
// queue has room. Each byte is parsed in the cycle it is accepted; any result it
// yields is written into a four-entry result queue that drives m_. A value word
// (function 5, 6 or 16) or coil byte (function 15) comes out as soon as its last
// byte arrives, and the final byte adds a frame summary after it, so one byte
// yields at most two results. s_ready is low while fewer than two queue slots are
// free; with m_ready held high the sustained rate is one byte per cycle. Bytes
// beyond MAX_FRAME_BYTES are not parsed and that frame's summary reports a length
// error. Fields not yet received read zero. State clears after every summary.

module modbus_tcp_request_deframer import mtrd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MTRD_MAX_FRAME_BYTES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    rslt_push_t push;
    logic       room;
    logic       in_fire;

    // a byte is taken whenever the queue can hold its results
    assign s_ready = room;
    assign in_fire = s_valid && room;

    // field capture and result forming
    mtrd_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_word (s_data),
        .push    (push)
    );

    // output buffering, decouples the parser from m_ready
    mtrd_result_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/mtrd_checker.sv
// port-level checks of the deframer and their bind
`timescale 1ns / 1ps
`include "modbus_tcp_request_deframer_assert.svh"

module mtrd_checker import mtrd_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    `MTRD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "stalled result changed")
    `MTRD_ASSERT_IMPLIES(a_summary_form, aclk, aresetn, m_valid && m_data.last,
        m_data.kind == KIND_SUMMARY && m_data.value == 16'd0 && m_data.index == 8'd0,
        "bad summary word")
    `MTRD_ASSERT_IMPLIES(a_value_form, aclk, aresetn, m_valid && !m_data.last,
        !m_data.length_ok && (m_data.kind == KIND_REG_WORD || m_data.kind == KIND_COIL_BYTE),
        "bad value word")
    `MTRD_ASSERT_IMPLIES(a_coil_form, aclk, aresetn, m_valid && m_data.kind == KIND_COIL_BYTE,
        m_data.value[15:8] == 8'd0 && m_data.func == FUNC_WRITE_MULTI_COILS, "bad coil byte")
    `MTRD_ASSERT_IMPLIES(a_single_form, aclk, aresetn, m_valid && !m_data.last
        && (m_data.func == FUNC_WRITE_SINGLE_COIL || m_data.func == FUNC_WRITE_SINGLE_REG),
        m_data.quantity == 16'd1 && m_data.index == 8'd0, "bad single write value")

endmodule

bind modbus_tcp_request_deframer mtrd_checker u_mtrd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
